// ===== rtl/wide_integer_alu_core_macros.svh =====
// Assertion macros for the wide integer ALU core.
`ifndef WIDE_INTEGER_ALU_CORE_MACROS_SVH
`define WIDE_INTEGER_ALU_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WIA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WIA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WIA_ASSERT(label, clk, rst_n, prop, msg)
`define WIA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/wia_pkg.sv =====
// Shared types and constants for the wide integer ALU core.
`timescale 1ns / 1ps
package wia_pkg;
    localparam int WORD_W = 128;
    localparam int HALF_W = 64;
    localparam int OP_W = 4;
    localparam int SH_W = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_AND = 4'd4, OP_OR = 4'd5, OP_XOR = 4'd6, OP_NOT = 4'd7,
        OP_SHL = 4'd8, OP_SAR = 4'd9, OP_ROL = 4'd10, OP_ROR = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0, KIND_MUL = 2'd1, KIND_DIV = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_FIX = 2'd2, ST_OUT = 2'd3
    } state_t;

    // Classified item passed from front to back.
    typedef struct packed {
        kind_t              kind;
        logic               neg_q;
        logic               neg_r;
        logic               dz;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
    } job_t;
endpackage

// ===== rtl/wia_front.sv =====
// Front end: decodes items, computes simple ops, prepares multiply/divide jobs.
`timescale 1ns / 1ps
module wia_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [wia_pkg::OP_W-1:0]   op,
    input  logic [wia_pkg::WORD_W-1:0] a,
    input  logic [wia_pkg::WORD_W-1:0] b,
    input  logic [wia_pkg::SH_W-1:0]   sh,
    output logic                       job_valid,
    input  logic                       job_ready,
    output wia_pkg::job_t              job
);
    wia_pkg::job_t job_reg, job_next;
    logic          valid_reg;
    logic [wia_pkg::WORD_W-1:0] na, nb, sar_r, direct;
    logic          an, bn;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        na = ~a + 1'b1;
        nb = ~b + 1'b1;
        an = a[wia_pkg::WORD_W-1];
        bn = b[wia_pkg::WORD_W-1];
        sar_r = $signed(a) >>> sh[6:0];
        if (sh >= 8'd128)
            sar_r = {wia_pkg::WORD_W{an}};
        direct = '0;
        case (op)
            wia_pkg::OP_ADD: direct = a + b;
            wia_pkg::OP_SUB: direct = a + nb;
            wia_pkg::OP_AND: direct = a & b;
            wia_pkg::OP_OR:  direct = a | b;
            wia_pkg::OP_XOR: direct = a ^ b;
            wia_pkg::OP_NOT: direct = ~a;
            wia_pkg::OP_SHL: direct = (sh >= 8'd128) ? '0 : (a << sh[6:0]);
            wia_pkg::OP_SAR: direct = sar_r;
            wia_pkg::OP_ROL: direct = {a[wia_pkg::WORD_W-2:0], a[wia_pkg::WORD_W-1]};
            wia_pkg::OP_ROR: direct = {a[0], a[wia_pkg::WORD_W-1:1]};
            default:         direct = '0;
        endcase
        job_next = '0;
        job_next.kind = wia_pkg::KIND_DIRECT;
        job_next.a = direct;
        if (op == wia_pkg::OP_MUL)
        begin
            job_next.kind = wia_pkg::KIND_MUL;
            job_next.a = a;
            job_next.b = b;
        end
        else if (op == wia_pkg::OP_DIV)
        begin
            if (b == '0)
            begin
                job_next.dz = 1'b1;
                job_next.a = '0;
            end
            else
            begin
                job_next.kind  = wia_pkg::KIND_DIV;
                job_next.neg_q = an ^ bn;
                job_next.neg_r = an;
                job_next.a = an ? na : a;
                job_next.b = bn ? nb : b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            job_reg <= job_next;
    end
endmodule

// ===== rtl/wia_queue.sv =====
// Short FIFO between front and back ends.
`timescale 1ns / 1ps
module wia_queue #(
    parameter int DEPTH = wia_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  wia_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output wia_pkg::job_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    wia_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != DEPTH[AW:0];
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== rtl/wia_back.sv =====
// Back end: bit-serial multiply and restoring divide, sign fix, output register.
`timescale 1ns / 1ps
`include "wide_integer_alu_core_macros.svh"
module wia_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  wia_pkg::job_t              job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2*wia_pkg::WORD_W:0] out_data
);
    localparam int W = wia_pkg::WORD_W;
    wia_pkg::state_t state_reg, state_next;
    wia_pkg::kind_t  kind_reg;
    logic            nq_reg, nr_reg, dz_reg;
    logic [W-1:0]    x_reg, y_reg, acc_reg, x_next, y_next, acc_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [W:0]      trial;
    logic [W-1:0]    rsh;
    logic            load;

    // a new job loads in idle, or in the same cycle the pending result transfers
    assign job_ready = (state_reg == wia_pkg::ST_IDLE)
                    || (state_reg == wia_pkg::ST_OUT && out_ready);
    assign load      = job_valid && job_ready;
    assign out_valid = state_reg == wia_pkg::ST_OUT;
    // {dz, remainder, result}
    assign out_data  = {dz_reg, acc_reg, x_reg};

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        rsh = {acc_reg[W-2:0], x_reg[W-1]};
        trial = {1'b0, rsh} - {1'b0, y_reg};
        case (state_reg)
            wia_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    x_next = job.a;
                    y_next = job.b;
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = (job.kind == wia_pkg::KIND_DIRECT) ? wia_pkg::ST_OUT
                                                                     : wia_pkg::ST_RUN;
                end
            end
            wia_pkg::ST_RUN:
            begin
                if (kind_reg == wia_pkg::KIND_MUL)
                begin
                    // shift-add over multiplier bits, low 128 bits kept
                    if (x_reg[0])
                        acc_next = acc_reg + y_reg;
                    x_next = x_reg >> 1;
                    y_next = y_reg << 1;
                end
                else
                begin
                    x_next = {x_reg[W-2:0], ~trial[W]};
                    acc_next = trial[W] ? rsh : trial[W-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 8'(W - 1))
                    state_next = wia_pkg::ST_FIX;
            end
            wia_pkg::ST_FIX:
            begin
                if (kind_reg == wia_pkg::KIND_MUL)
                begin
                    x_next = acc_reg;
                    acc_next = '0;
                end
                else
                begin
                    if (nq_reg)
                        x_next = ~x_reg + 1'b1;
                    if (nr_reg)
                        acc_next = ~acc_reg + 1'b1;
                end
                state_next = wia_pkg::ST_OUT;
            end
            wia_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = wia_pkg::ST_IDLE;
                    if (job_valid)
                    begin
                        x_next = job.a;
                        y_next = job.b;
                        acc_next = '0;
                        cnt_next = '0;
                        state_next = (job.kind == wia_pkg::KIND_DIRECT) ? wia_pkg::ST_OUT
                                                                         : wia_pkg::ST_RUN;
                    end
                end
            end
            default: state_next = wia_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wia_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        if (load)
        begin
            kind_reg <= job.kind;
            nq_reg <= job.neg_q;
            nr_reg <= job.neg_r;
            dz_reg <= job.dz;
        end
    end

    `WIA_ASSERT(a_load_idle, clk, rst_n, load |=> state_reg != wia_pkg::ST_IDLE, "load lost")
    `WIA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(out_data), "output changed while stalled")
    `WIA_ASSERT(a_run_fix, clk, rst_n, (state_reg == wia_pkg::ST_RUN && cnt_reg == 8'(W - 1)) |=> state_reg == wia_pkg::ST_FIX, "iteration count wrong")
endmodule

// ===== rtl/wide_integer_alu_core.sv =====
// Each item passes the front register and the queue before the back end loads it.
// Multiply and divide share one 128-step shift/add-subtract loop, one bit per cycle;
// the back end loads, iterates and sign-fixes each multiply or divide before it takes the next job.
// Front end and a 2-entry queue keep accepting while the back end iterates.
// Reset (rst_n, async, active low) empties the front register, queue and back end.
`timescale 1ns / 1ps
module wide_integer_alu_core #(
    parameter int QUEUE_DEPTH = wia_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[3:0], operand_a_hi[67:4], operand_a_lo[131:68], operand_b_hi[195:132],
    // operand_b_lo[259:196], shift_amount[267:260], zero pad to 272
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_hi[63:0], result_lo[127:64], remainder_hi[191:128], remainder_lo[255:192]
    output logic [255:0] m_axis_tdata,
    // divide_by_zero
    output logic         m_axis_tuser
);
    wia_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [2*wia_pkg::WORD_W:0] bd;
    logic [wia_pkg::WORD_W-1:0] a, b;

    assign a = {s_axis_tdata[67:4], s_axis_tdata[131:68]};
    assign b = {s_axis_tdata[195:132], s_axis_tdata[259:196]};

    wia_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tdata[3:0]), .a(a), .b(b), .sh(s_axis_tdata[267:260]),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    wia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    wia_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(bd)
    );

    assign m_axis_tdata = {bd[191:128], bd[255:192], bd[63:0], bd[127:64]};
    assign m_axis_tuser = bd[256];
endmodule

// ===== test/testbench.sv =====
// Stream testbench for wide_integer_alu_core: directed and random operations checked against a local predictor.
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [3:0]   op;
        logic [127:0] a;
        logic [127:0] b;
        logic [7:0]   sh;
    } alu_req_t;

    typedef struct {
        logic [127:0] res;
        logic [127:0] rem;
        logic         dz;
    } alu_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [271:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;
    logic         m_axis_tuser;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int       errors = 0;
    int       checked = 0;
    int       sent = 0;
    int       n_divs = 0;
    int       n_dz = 0;
    int       drv_gap = 0;
    int       mon_gap = 0;
    bit       feed_done = 0;
    bit       in_taken = 0;
    longint   cycles = 0;

    localparam longint CYCLE_LIMIT = 3000000;

    wide_integer_alu_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [127:0] neg128(logic [127:0] v);
        return ~v + 128'd1;
    endfunction

    function automatic alu_res_t alu_compute(alu_req_t r);
        alu_res_t     o;
        logic [127:0] ma, mb, q, rm;
        logic         an, bn;
        o.res = '0;
        o.rem = '0;
        o.dz = 1'b0;
        case (r.op)
            wia_pkg::OP_ADD: o.res = r.a + r.b;
            wia_pkg::OP_SUB: o.res = r.a - r.b;
            wia_pkg::OP_MUL: o.res = r.a * r.b;
            wia_pkg::OP_DIV:
            begin
                if (r.b == '0)
                    o.dz = 1'b1;
                else
                begin
                    an = r.a[127];
                    bn = r.b[127];
                    ma = an ? neg128(r.a) : r.a;
                    mb = bn ? neg128(r.b) : r.b;
                    q = ma / mb;
                    rm = ma % mb;
                    o.res = (an != bn) ? neg128(q) : q;
                    o.rem = an ? neg128(rm) : rm;
                end
            end
            wia_pkg::OP_AND: o.res = r.a & r.b;
            wia_pkg::OP_OR:  o.res = r.a | r.b;
            wia_pkg::OP_XOR: o.res = r.a ^ r.b;
            wia_pkg::OP_NOT: o.res = ~r.a;
            wia_pkg::OP_SHL: o.res = (r.sh >= 128) ? '0 : r.a << r.sh;
            wia_pkg::OP_SAR:
            begin
                o.res = $signed(r.a) >>> r.sh;
                if (r.sh >= 128)
                    o.res = {128{r.a[127]}};
            end
            wia_pkg::OP_ROL: o.res = {r.a[126:0], r.a[127]};
            wia_pkg::OP_ROR: o.res = {r.a[0], r.a[127:1]};
            default: ;
        endcase
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = {1'b1, 127'd0};
            3: v = {1'b0, {127{1'b1}}};
            4: v = {{96{v[31]}}, v[31:0]};
            5: v = 128'($urandom_range(0, 20));
            6: v = neg128(128'($urandom_range(1, 20)));
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_req(logic [3:0] op, logic [127:0] a, logic [127:0] b, logic [7:0] sh);
        alu_req_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        r.sh = sh;
        pending_reqs.push_back(r);
    endtask

    always @(negedge clk)
    begin
        alu_req_t r;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
                ;
            else if (drv_gap > 0)
            begin
                drv_gap <= drv_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                s_axis_tdata <= {4'd0, r.sh, r.b[63:0], r.b[127:64], r.a[63:0], r.a[127:64], r.op};
                s_axis_tvalid <= 1'b1;
                expected_results.push_back(alu_compute(r));
                sent <= sent + 1;
                if (r.op == wia_pkg::OP_DIV)
                    n_divs <= n_divs + 1;
                if (r.op == wia_pkg::OP_DIV && r.b == '0)
                    n_dz <= n_dz + 1;
                drv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
            if (mon_gap > 0)
            begin
                mon_gap <= mon_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    mon_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        alu_res_t e;
        cycles <= cycles + 1;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h dz %b", $time, m_axis_tdata, m_axis_tuser);
                errors <= errors + 1;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tdata[63:0] !== e.res[127:64] || m_axis_tdata[127:64] !== e.res[63:0]
                    || m_axis_tdata[191:128] !== e.rem[127:64]
                    || m_axis_tdata[255:192] !== e.rem[63:0] || m_axis_tuser !== e.dz)
                begin
                    $display("%0t: mismatch expected res %h rem %h dz %b", $time, e.res, e.rem,
                        e.dz);
                    $display("%0t:          actual res %h rem %h dz %b", $time,
                        {m_axis_tdata[63:0], m_axis_tdata[127:64]},
                        {m_axis_tdata[191:128], m_axis_tdata[255:192]}, m_axis_tuser);
                    errors <= errors + 1;
                end
                checked <= checked + 1;
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] mn;
        int op_i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mn = {1'b1, 127'd0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (op_i = wia_pkg::OP_ADD; op_i <= wia_pkg::OP_ROR; op_i++)
            push_req(4'(op_i), '1, mn, 8'd1);
        push_req(wia_pkg::OP_ADD, '1, 128'd1, 8'd0);
        push_req(wia_pkg::OP_SUB, '0, 128'd1, 8'd0);
        push_req(wia_pkg::OP_MUL, mn, '1, 8'd0);
        push_req(wia_pkg::OP_DIV, 128'd100, '0, 8'd0);
        push_req(wia_pkg::OP_DIV, mn, '1, 8'd0);
        push_req(wia_pkg::OP_DIV, neg128(128'd7), 128'd2, 8'd0);
        push_req(wia_pkg::OP_DIV, 128'd7, neg128(128'd2), 8'd0);
        push_req(wia_pkg::OP_SHL, '1, '0, 8'd128);
        push_req(wia_pkg::OP_SHL, '1, '0, 8'd255);
        push_req(wia_pkg::OP_SAR, mn, '0, 8'd200);
        push_req(wia_pkg::OP_SAR, mn, '0, 8'd64);
        push_req(wia_pkg::OP_SAR, '1 >> 1, '0, 8'd0);
        push_req(wia_pkg::OP_ROL, '0, '0, 8'd77);
        push_req(4'd15, '1, '1, 8'd255);

        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        // hold the sender until the pipe is empty
        @(negedge clk);

        repeat (1100)
        begin
            if ($urandom_range(0, 9) < 3)
                op_i = $urandom_range(wia_pkg::OP_MUL, wia_pkg::OP_DIV);
            else
                op_i = $urandom_range(0, 15);
            push_req(4'(op_i), rand_operand(), ($urandom_range(0, 29) == 0) ? '0 : rand_operand(),
                8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 130)));
            if ($urandom_range(0, 299) == 0)
            begin
                while (pending_reqs.size() != 0 || expected_results.size() != 0)
                    @(posedge clk);
            end
        end

        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (300) @(posedge clk);
        #1;
        $display("Sent %0d operations (%0d divides, %0d by zero), checked %0d results.",
            sent, n_divs, n_dz, checked);
        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
